/* sv/bvs_pkg.sv */
// Package with shared types, constants and codes for the bencode value skipper.
`timescale 1ns / 1ps
`default_nettype none

package bvs_pkg;

   // Counter widths.
   localparam int LEN_BITS      = 32;
   localparam int LEN_WIDE_BITS = LEN_BITS + 4;
   localparam int DEPTH_BITS    = 8;

   // Queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Special characters.
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_L     = 8'h6C;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Byte classes produced by the front part.
   localparam logic [2:0] CLS_OTHER = 3'd0;
   localparam logic [2:0] CLS_DIGIT = 3'd1;
   localparam logic [2:0] CLS_COLON = 3'd2;
   localparam logic [2:0] CLS_INT   = 3'd3;
   localparam logic [2:0] CLS_END   = 3'd4;
   localparam logic [2:0] CLS_OPEN  = 3'd5;

   // Error codes reported with each result.
   localparam logic [2:0] ERR_OK         = 3'd0;
   localparam logic [2:0] ERR_BAD_TYPE   = 3'd1;
   localparam logic [2:0] ERR_BAD_DIGIT  = 3'd2;
   localparam logic [2:0] ERR_LEN_OVF    = 3'd3;
   localparam logic [2:0] ERR_DEPTH_OVF  = 3'd4;
   localparam logic [2:0] ERR_NO_COLON   = 3'd5;
   localparam logic [2:0] ERR_STR_SHORT  = 3'd6;
   localparam logic [2:0] ERR_UNTERM     = 3'd7;

   // Input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   // Result beat.
   typedef struct packed {
      logic       value_end;
      logic       in_payload;
      logic [7:0] nest_depth;
      logic [2:0] error_code;
   } rsp_item_type;

   // Classified byte held in the queue.
   typedef struct packed {
      logic [2:0] byte_class;
      logic [3:0] digit;
      logic       last_byte;
   } class_item_type;

   // Queue status seen by the front and back parts.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

/* sv/bencode_value_skipper_unit.sv */
// Top level of the bencode value skipper: front classifier, queue and back parser.
`timescale 1ns / 1ps
`default_nettype none

// The unit takes one byte of bencoded data per beat and returns one result beat per
// byte: whether the byte completes the top-level value, whether it is string payload,
// the container depth after it and an error code. It sustains one byte per clock
// while results are taken. A byte is classified on entry and written into a
// two-entry queue; the back part updates the parse state for the head byte
// combinationally and registers the result, so each byte passes through a queue
// entry and then the result register. The queue absorbs a stalled result channel,
// and input is held off only when it is full. There are no configuration registers.
module bencode_value_skipper_unit
   import bvs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_item_type req_item,
   input  wire logic         req_valid,
   output logic              req_ready,
   output rsp_item_type      rsp_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready
);

   queue_status_type q_status;
   class_item_type   push_item;
   class_item_type   head_item;
   logic             push;
   logic             pop;

   bvs_front u_front (
      .req_item  (req_item),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   bvs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   bvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   // A completed value always reports depth zero and no error.
   a_end_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.value_end |->
         (rsp_item.nest_depth == 8'd0) && (rsp_item.error_code == ERR_OK))
      else $error("value end with nonzero depth or error");

   // A payload byte is either fine or flags a buffer that ended inside the value.
   a_payload_err : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.in_payload |->
         (rsp_item.error_code == ERR_OK) || (rsp_item.error_code == ERR_STR_SHORT) ||
         (rsp_item.error_code == ERR_UNTERM))
      else $error("payload byte with unexpected error code");

   // No result is presented right after reset.
   a_reset_idle : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Input is refused only while a result is stuck on the output.
   a_ready_backpressure : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

`default_nettype wire

/* sv/bvs_front.sv */
// Front part: classifies each input byte and pushes it into the queue.
`timescale 1ns / 1ps
`default_nettype none

module bvs_front
   import bvs_pkg::*;
(
   input  wire req_item_type     req_item,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire queue_status_type q_status,
   output logic                  push,
   output class_item_type        push_item
);

   logic       is_digit;
   logic [7:0] digit_wide;

   // Accept a beat whenever the queue has room.
   assign req_ready = !q_status.full;
   assign push      = req_valid && !q_status.full;

   // Decode the byte into a class and a digit value.
   assign is_digit   = (req_item.data_byte >= CH_ZERO) && (req_item.data_byte <= CH_NINE);
   assign digit_wide = req_item.data_byte - CH_ZERO;

   always_comb begin
      push_item.digit     = digit_wide[3:0];
      push_item.last_byte = req_item.last_byte;
      if (is_digit) begin
         push_item.byte_class = CLS_DIGIT;
      end else if (req_item.data_byte == CH_COLON) begin
         push_item.byte_class = CLS_COLON;
      end else if (req_item.data_byte == CH_I) begin
         push_item.byte_class = CLS_INT;
      end else if (req_item.data_byte == CH_E) begin
         push_item.byte_class = CLS_END;
      end else if (req_item.data_byte == CH_L || req_item.data_byte == CH_D) begin
         push_item.byte_class = CLS_OPEN;
      end else begin
         push_item.byte_class = CLS_OTHER;
      end
   end

endmodule

`default_nettype wire

/* sv/bvs_queue.sv */
// Short queue of classified bytes between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module bvs_queue
   import bvs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire class_item_type push_item,
   input  wire logic           pop,
   output class_item_type      head_item,
   output queue_status_type    q_status
);

   class_item_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_item      = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

/* sv/bvs_back.sv */
// Back part: parse state machine and registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module bvs_back
   import bvs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type q_status,
   input  wire class_item_type   head_item,
   output logic                  pop,
   output rsp_item_type          rsp_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready
);

   // Parse phases.
   localparam logic [1:0] PH_EXPECT  = 2'd0;
   localparam logic [1:0] PH_INT     = 2'd1;
   localparam logic [1:0] PH_LEN     = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

   logic [1:0]            phase_ff, phase_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic                  seen_ff, seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   logic [1:0]              phase_n;
   logic [DEPTH_BITS-1:0]   depth_n;
   logic [DEPTH_BITS-1:0]   depth_out;
   logic [LEN_BITS-1:0]     len_n;
   logic                    seen_n;
   logic [2:0]              err;
   logic                    done;
   logic                    payload;
   logic                    vend;
   logic [LEN_WIDE_BITS-1:0] len_times_ten;

   // A queued byte is taken whenever the result register is free or draining.
   assign pop       = !q_status.empty && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Next length when one more digit is appended; the top bits flag overflow.
   assign len_times_ten = LEN_WIDE_BITS'({len_ff, 3'b000}) + LEN_WIDE_BITS'({len_ff, 1'b0})
                        + LEN_WIDE_BITS'(head_item.digit);

   // Per-byte state update.
   always_comb begin
      phase_n = phase_ff;
      depth_n = depth_ff;
      len_n   = len_ff;
      seen_n  = seen_ff;
      err     = ERR_OK;
      done    = 1'b0;
      payload = 1'b0;
      unique case (phase_ff)
         PH_EXPECT: begin
            if (head_item.byte_class == CLS_END && depth_ff != '0) begin
               depth_n = depth_ff - 1'b1;
               done    = 1'b1;
            end else if (head_item.byte_class == CLS_INT) begin
               phase_n = PH_INT;
            end else if (head_item.byte_class == CLS_OPEN) begin
               if (depth_ff == DEPTH_MAX) begin
                  err = ERR_DEPTH_OVF;
               end else begin
                  depth_n = depth_ff + 1'b1;
               end
            end else if (head_item.byte_class == CLS_DIGIT) begin
               phase_n = PH_LEN;
               len_n   = LEN_BITS'(head_item.digit);
               seen_n  = 1'b1;
            end else begin
               err = ERR_BAD_TYPE;
            end
         end
         PH_INT: begin
            if (head_item.byte_class == CLS_END) begin
               phase_n = PH_EXPECT;
               done    = 1'b1;
            end
         end
         PH_LEN: begin
            if (head_item.byte_class == CLS_DIGIT) begin
               if (len_times_ten[LEN_WIDE_BITS-1:LEN_BITS] != '0) begin
                  err = ERR_LEN_OVF;
               end else begin
                  len_n  = len_times_ten[LEN_BITS-1:0];
                  seen_n = 1'b1;
               end
            end else if (head_item.byte_class == CLS_COLON) begin
               if (!seen_ff) begin
                  err = ERR_BAD_DIGIT;
               end else if (len_ff == '0) begin
                  phase_n = PH_EXPECT;
                  done    = 1'b1;
               end else begin
                  phase_n = PH_PAYLOAD;
               end
               seen_n = 1'b0;
            end else begin
               err = ERR_BAD_DIGIT;
            end
         end
         PH_PAYLOAD: begin
            payload = 1'b1;
            len_n   = len_ff - 1'b1;
            if (len_ff == LEN_BITS'(1)) begin
               phase_n = PH_EXPECT;
               done    = 1'b1;
            end
         end
         default: begin
            phase_n = PH_EXPECT;
         end
      endcase

      vend = (err == ERR_OK) && done && (depth_n == '0);

      // The buffer ended before the value did.
      if (err == ERR_OK && !vend && head_item.last_byte) begin
         if (phase_n == PH_LEN) begin
            err = ERR_NO_COLON;
         end else if (phase_n == PH_PAYLOAD) begin
            err = ERR_STR_SHORT;
         end else begin
            err = ERR_UNTERM;
         end
      end

      if (vend) begin
         depth_out = '0;
      end else if (err != ERR_OK) begin
         depth_out = depth_ff;
      end else begin
         depth_out = depth_n;
      end

      // A finished value, an error or the end of the buffer starts afresh.
      if (err != ERR_OK || vend || head_item.last_byte) begin
         phase_n = PH_EXPECT;
         depth_n = '0;
         len_n   = '0;
         seen_n  = 1'b0;
      end
   end

   // Register next values only when a byte is taken.
   always_comb begin
      phase_in     = pop ? phase_n : phase_ff;
      depth_in     = pop ? depth_n : depth_ff;
      len_in       = pop ? len_n   : len_ff;
      seen_in      = pop ? seen_n  : seen_ff;
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
      rsp_item_in  = rsp_item_ff;
      if (pop) begin
         rsp_item_in.value_end  = vend;
         rsp_item_in.in_payload = payload;
         rsp_item_in.nest_depth = 8'(depth_out);
         rsp_item_in.error_code = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_EXPECT;
         depth_ff     <= '0;
         len_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         depth_ff     <= depth_in;
         len_ff       <= len_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

endmodule

`default_nettype wire

/* bench/tb_bencode_value_skipper_unit.sv */
// Self-checking testbench for the bencode value skipper unit.
`timescale 1ns / 1ps

module tb_bencode_value_skipper_unit;
   import bvs_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 370;
   localparam int REPORT_LIMIT = 10;

   // Parse phases of the scanner copy kept by the bench.
   typedef enum logic [1:0] {
      SCAN_VALUE,
      SCAN_INTEGER,
      SCAN_LENGTH,
      SCAN_STRING
   } scan_phase_type;

   // One row of the directed table.
   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type want;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   req_item_type req_item = '0;
   logic         req_valid = 1'b0;
   logic         req_ready;
   rsp_item_type rsp_item;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;

   // Scanner state mirrored by the bench.
   scan_phase_type        scan_phase;
   logic [DEPTH_BITS-1:0] scan_depth;
   logic [LEN_BITS-1:0]   scan_len;
   logic                  scan_digit_seen;

   rsp_item_type     expected_rsp_q[$];
   directed_row_type directed_rows[$];
   req_item_type     packet_q[$];

   int   fault_count = 0;
   int   items_sent = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_left = 0;
   bit   hold_taken = 1'b0;
   logic hold_off_go = 1'b0;
   int   quiet_cycles = 0;

   bencode_value_skipper_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready)
   );

   always #2 clock = ~clock;

   // Return the scanner to the start of a new value.
   function automatic void clear_scan();
      scan_phase      = SCAN_VALUE;
      scan_depth      = '0;
      scan_len        = '0;
      scan_digit_seen = 1'b0;
   endfunction

   // Advance the scanner by one byte and return the result beat it produces.
   function automatic rsp_item_type predict_skip(input req_item_type it);
      rsp_item_type          r;
      logic [7:0]            b;
      logic                  is_digit;
      logic                  done;
      logic                  payload;
      logic                  vend;
      logic [2:0]            err;
      logic [DEPTH_BITS-1:0] depth_before;
      logic [63:0]           d;
      logic [63:0]           len_max;
      b            = it.data_byte;
      is_digit     = (b >= CH_ZERO) && (b <= CH_NINE);
      done         = 1'b0;
      payload      = 1'b0;
      err          = ERR_OK;
      depth_before = scan_depth;
      d            = 64'(b - CH_ZERO);
      len_max      = (64'd1 << LEN_BITS) - 64'd1;
      case (scan_phase)
         SCAN_VALUE: begin
            if (b == CH_E && scan_depth != 0) begin
               scan_depth = scan_depth - 1'b1;
               done       = 1'b1;
            end else if (b == CH_I) begin
               scan_phase = SCAN_INTEGER;
            end else if (b == CH_L || b == CH_D) begin
               if (scan_depth == '1) err = ERR_DEPTH_OVF;
               else scan_depth = scan_depth + 1'b1;
            end else if (is_digit) begin
               scan_phase      = SCAN_LENGTH;
               scan_len        = LEN_BITS'(d);
               scan_digit_seen = 1'b1;
            end else begin
               err = ERR_BAD_TYPE;
            end
         end
         SCAN_INTEGER: begin
            if (b == CH_E) begin
               scan_phase = SCAN_VALUE;
               done       = 1'b1;
            end
         end
         SCAN_LENGTH: begin
            if (is_digit) begin
               if (64'(scan_len) > (len_max - d) / 64'd10) begin
                  err = ERR_LEN_OVF;
               end else begin
                  scan_len        = LEN_BITS'(64'(scan_len) * 64'd10 + d);
                  scan_digit_seen = 1'b1;
               end
            end else if (b == CH_COLON) begin
               if (!scan_digit_seen) begin
                  err = ERR_BAD_DIGIT;
               end else if (scan_len == 0) begin
                  scan_phase = SCAN_VALUE;
                  done       = 1'b1;
               end else begin
                  scan_phase = SCAN_STRING;
               end
               scan_digit_seen = 1'b0;
            end else begin
               err = ERR_BAD_DIGIT;
            end
         end
         default: begin
            payload  = 1'b1;
            scan_len = scan_len - 1'b1;
            if (scan_len == 0) begin
               scan_phase = SCAN_VALUE;
               done       = 1'b1;
            end
         end
      endcase
      vend = (err == ERR_OK) && done && (scan_depth == 0);
      // A buffer that ends before the value does is reported by where it stopped.
      if (err == ERR_OK && !vend && it.last_byte) begin
         if (scan_phase == SCAN_LENGTH) err = ERR_NO_COLON;
         else if (scan_phase == SCAN_STRING) err = ERR_STR_SHORT;
         else err = ERR_UNTERM;
      end
      r.value_end  = vend;
      r.in_payload = payload;
      r.nest_depth = 8'((err != ERR_OK) ? depth_before : scan_depth);
      if (vend) r.nest_depth = '0;
      r.error_code = err;
      if (err != ERR_OK || vend || it.last_byte) clear_scan();
      return r;
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic last, input bit typed,
                                   input logic vend, input logic pay, input logic [7:0] depth,
                                   input logic [2:0] err);
      directed_row_type row;
      row.item  = '{data_byte: b, last_byte: last};
      row.typed = typed;
      row.want  = '{value_end: vend, in_payload: pay, nest_depth: depth, error_code: err};
      directed_rows.push_back(row);
   endfunction

   function automatic void push_byte(input logic [7:0] b);
      packet_q.push_back('{data_byte: b, last_byte: 1'b0});
   endfunction

   function automatic void push_number(input int unsigned v);
      string s;
      int    i;
      s = $sformatf("%0d", v);
      for (i = 0; i < s.len(); i++) push_byte(s[i]);
   endfunction

   // Append one well-formed value with random content.
   function automatic void gen_value(input int lvl);
      int         kind;
      int         n;
      int         i;
      logic [7:0] b;
      kind = $urandom_range(0, 9);
      if (lvl >= 4 && kind >= 7) kind = $urandom_range(0, 6);
      if (kind <= 2) begin
         push_byte(CH_I);
         n = $urandom_range(0, 5);
         for (i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_E) b = CH_ZERO;
            push_byte(b);
         end
         push_byte(CH_E);
      end else if (kind <= 6) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
         if ($urandom_range(0, 7) == 0) push_byte(CH_ZERO);
         push_number(n);
         push_byte(CH_COLON);
         for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
      end else begin
         push_byte(($urandom_range(0, 1) == 0) ? CH_L : CH_D);
         n = $urandom_range(0, 3);
         for (i = 0; i < n; i++) gen_value(lvl + 1);
         push_byte(CH_E);
      end
   endfunction

   // Nest to the maximum depth, then either open once more or close every level.
   function automatic void gen_deep(input bit overflow);
      int i;
      for (i = 0; i < 255; i++) push_byte(CH_L);
      if (overflow) begin
         push_byte(CH_D);
      end else begin
         for (i = 0; i < 255; i++) push_byte(CH_E);
      end
   endfunction

   // Long string lengths around the counter limit, closed by a final colon.
   function automatic void gen_long_length();
      int i;
      int n;
      case ($urandom_range(0, 2))
         0: push_number(32'd4294967295);
         1: begin
            push_number(32'd429496729);
            push_byte(CH_ZERO + 8'd6);
         end
         default: begin
            n = $urandom_range(10, 12);
            for (i = 0; i < n; i++) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
         end
      endcase
      push_byte(CH_COLON);
   endfunction

   function automatic void mark_tail_last();
      req_item_type it;
      it               = packet_q[$];
      it.last_byte     = 1'b1;
      packet_q[$]      = it;
   endfunction

   // Build one random packet: mostly whole values, some cut, spoiled, noise, long lengths or deep nesting.
   function automatic void build_random_packet();
      int           kind;
      int           keep;
      int           pos;
      int           n;
      int           i;
      req_item_type it;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         gen_value(0);
         if ($urandom_range(0, 2) == 0) mark_tail_last();
      end else if (kind < 80) begin
         gen_value(0);
         if (packet_q.size() > 1) begin
            keep = $urandom_range(1, packet_q.size() - 1);
            while (packet_q.size() > keep) void'(packet_q.pop_back());
         end
         mark_tail_last();
      end else if (kind < 88) begin
         gen_value(0);
         pos            = $urandom_range(0, packet_q.size() - 1);
         it             = packet_q[pos];
         it.data_byte   = 8'($urandom_range(0, 255));
         packet_q[pos]  = it;
         if ($urandom_range(0, 2) == 0) mark_tail_last();
      end else if (kind < 96) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) begin
            push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 3) == 0) mark_tail_last();
         end
      end else if (kind < 99) begin
         gen_long_length();
         mark_tail_last();
      end else begin
         gen_deep($urandom_range(0, 1));
      end
   endfunction

   // Offer one beat, wait for the handshake and record what it should produce.
   task automatic send_byte(input req_item_type it, input bit typed, input rsp_item_type want);
      rsp_item_type predicted;
      // Each cycle before the offer idles with the sender's idle share.
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = predict_skip(it);
      expected_rsp_q.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   task automatic flush_packet();
      int i;
      for (i = 0; i < packet_q.size(); i++) send_byte(packet_q[i], 1'b0, '0);
      packet_q.delete();
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic log_fault(input string what, input rsp_item_type want,
                            input rsp_item_type got);
      if (fault_count < REPORT_LIMIT)
         $display("%0t: %s: expected end=%0b pay=%0b depth=%0d err=%0d,",
                  $realtime, what, want.value_end, want.in_payload, want.nest_depth,
                  want.error_code, " got end=%0b pay=%0b depth=%0d err=%0d",
                  got.value_end, got.in_payload, got.nest_depth, got.error_code);
      fault_count++;
   endtask

   // Result side: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               log_fault("result beat with nothing expected", '0, rsp_item);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_item.value_end !== want.value_end ||
                   rsp_item.in_payload !== want.in_payload ||
                   rsp_item.nest_depth !== want.nest_depth ||
                   rsp_item.error_code !== want.error_code)
                  log_fault("result mismatch", want, rsp_item);
            end
         end
         // One long hold-off lets the block fill up and push back on its input.
         if (hold_off_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_bencode_value_skipper_unit: errors");
            $finish;
         end
      end
   end

   // Stimulus: directed table, then three random phases with different idling.
   initial begin
      int ph;
      int phase_start;
      int i;
      clear_scan();
      // Bytes that cannot start a value, byte extremes among them.
      add_row(CH_E,     1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_BAD_TYPE);
      add_row(CH_COLON, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_BAD_TYPE);
      add_row(8'h00,    1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_BAD_TYPE);
      add_row(8'hFF,    1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ERR_BAD_TYPE);
      // Empty string, one-byte string, empty integer and empty list.
      add_row(CH_ZERO,  1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row(CH_COLON, 1'b0, 1'b1, 1'b1, 1'b0, 8'd0, ERR_OK);
      add_row("1",      1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row(CH_COLON, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row(8'hFF,    1'b0, 1'b1, 1'b1, 1'b1, 8'd0, ERR_OK);
      add_row(CH_I,     1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row(CH_E,     1'b0, 1'b1, 1'b1, 1'b0, 8'd0, ERR_OK);
      add_row(CH_L,     1'b0, 1'b1, 1'b0, 1'b0, 8'd1, ERR_OK);
      add_row(CH_E,     1'b0, 1'b1, 1'b1, 1'b0, 8'd0, ERR_OK);
      // Non-digit inside a length.
      add_row("5",      1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row("x",      1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_BAD_DIGIT);
      // Buffer ends in a length, right after the colon, and in an integer.
      add_row("3",      1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ERR_NO_COLON);
      add_row("2",      1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row(CH_COLON, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ERR_STR_SHORT);
      add_row(CH_I,     1'b1, 1'b1, 1'b0, 1'b0, 8'd0, ERR_UNTERM);
      // Errors inside a container report the depth held before the byte.
      add_row(CH_D,     1'b0, 1'b1, 1'b0, 1'b0, 8'd1, ERR_OK);
      add_row("x",      1'b0, 1'b1, 1'b0, 1'b0, 8'd1, ERR_BAD_TYPE);
      add_row(CH_L,     1'b0, 1'b1, 1'b0, 1'b0, 8'd1, ERR_OK);
      add_row(CH_L,     1'b1, 1'b1, 1'b0, 1'b0, 8'd1, ERR_UNTERM);
      // Buffer ends on a payload byte with more still owed.
      add_row("3",      1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row(CH_COLON, 1'b0, 1'b1, 1'b0, 1'b0, 8'd0, ERR_OK);
      add_row("a",      1'b1, 1'b1, 1'b0, 1'b1, 8'd0, ERR_STR_SHORT);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed_rows.size(); i++)
         send_byte(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      for (ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct <= 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct <= 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
               hold_off_go   <= 1'b1;
            end
         endcase
         // Maximum nesting: overflow it in the first phase, close it in the second.
         if (ph < 2) begin
            gen_deep(ph == 0);
            flush_packet();
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            build_random_packet();
            flush_packet();
         end
         drain_results();
      end

      repeat (8) @(posedge clock);
      if (fault_count == 0 && expected_rsp_q.size() == 0) begin
         $display("tb_bencode_value_skipper_unit: clean");
      end else begin
         $display("tb_bencode_value_skipper_unit: errors");
      end
      $finish;
   end

endmodule

/* files.f */
sv/bvs_pkg.sv
sv/bvs_front.sv
sv/bvs_queue.sv
sv/bvs_back.sv
sv/bencode_value_skipper_unit.sv
bench/tb_bencode_value_skipper_unit.sv
